// File: design/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared types and constants of the cubic Bezier point evaluator: the
// configuration register indexes and the pipeline depth.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpe_pkg;

    // Configuration index width: wide enough to address past the last register
    localparam int unsigned CFG_IDX_BITS = 3;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    // Register indexes
    localparam cfg_idx_t REG_POINT_A = 3'd0;
    localparam cfg_idx_t REG_POINT_B = 3'd1;
    localparam cfg_idx_t REG_POINT_C = 3'd2;
    localparam cfg_idx_t REG_POINT_D = 3'd3;

    // Number of control points and axes
    localparam int unsigned NUM_POINTS = 4;
    localparam int unsigned NUM_AXES   = 3;

    // Pipeline: input register, then multiply and round stages per level
    localparam int unsigned NUM_STAGES = 7;

endpackage

`default_nettype wire

// File: design/cubic_bezier_point_eval_unit.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_unit
// Cubic Bezier curve point evaluator in 3D using de Casteljau's scheme in
// fixed point, as a seven-stage pipeline with per-stage valid bits.
// ----------------------------------------------------------------------------
// Takes one parameter value per cycle and returns one curve point per cycle
// while the output is not stalled. Each item passes through an input register
// that clamps t to 1.0, then for each of the three interpolation levels one
// stage that forms t * (b - a) in a 17 x 18 multiplier per lerp and one
// stage that rounds to nearest and adds the base point. Each stage holds its
// item while the next one is full, so a stalled output only stops the
// upstream stages once every stage holds an item. The four control points
// are written through the plain write port and must only be changed while
// no item is in flight.
`default_nettype none

module cubic_bezier_point_eval_unit #(
    parameter int unsigned COORD_BITS      = 16,
    parameter int unsigned PARAM_FRAC_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [cbpe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [3*COORD_BITS-1:0]             cfg_wr_data,
    // parameter input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [PARAM_FRAC_BITS:0]            s_t_fraction,
    // curve point output
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [COORD_BITS-1:0]             m_out_x,
    output logic signed [COORD_BITS-1:0]             m_out_y,
    output logic signed [COORD_BITS-1:0]             m_out_z
);

    localparam int unsigned CB  = COORD_BITS;
    localparam int unsigned FB  = PARAM_FRAC_BITS;
    localparam int unsigned TB  = FB + 1;
    localparam int unsigned PW  = CB + FB + 3;
    localparam int unsigned NS  = cbpe_pkg::NUM_STAGES;
    localparam int unsigned NP  = cbpe_pkg::NUM_POINTS;
    localparam int unsigned NA  = cbpe_pkg::NUM_AXES;
    localparam logic [TB-1:0]        T_ONE    = TB'(1) << FB;
    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (FB - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3*CB-1:0] point_reg [NP];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NP; i++) begin
                point_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cbpe_pkg::REG_POINT_A: point_reg[0] <= cfg_wr_data;
                cbpe_pkg::REG_POINT_B: point_reg[1] <= cfg_wr_data;
                cbpe_pkg::REG_POINT_C: point_reg[2] <= cfg_wr_data;
                cbpe_pkg::REG_POINT_D: point_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Unpack control point coordinates per axis
    logic signed [CB-1:0] ctrl [NA][NP];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            for (int k = 0; k < NP; k++) begin
                ctrl[j][k] = point_reg[k][j*CB +: CB];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage advance chain: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic          valid_reg [NS];
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = m_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Parameter pipeline (t needed at stages 1, 3 and 5)
    // ------------------------------------------------------------------
    logic [TB-1:0] t_reg [5];
    logic [TB-1:0] t_next;

    // clamp t to 1.0
    always_comb begin
        if (s_t_fraction[FB] && (|s_t_fraction[FB-1:0])) begin
            t_next = T_ONE;
        end else begin
            t_next = s_t_fraction;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            t_reg[0] <= t_next;
        end
        for (int i = 1; i < 5; i++) begin
            if (adv[i]) begin
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    // Signed views of t for the multipliers
    logic signed [TB:0] t1_s, t3_s, t5_s;

    assign t1_s = signed'({1'b0, t_reg[0]});
    assign t3_s = signed'({1'b0, t_reg[2]});
    assign t5_s = signed'({1'b0, t_reg[4]});

    // ------------------------------------------------------------------
    // Level 1: three lerps per axis
    // ------------------------------------------------------------------
    logic signed [CB-1:0] base1_reg [NA][3];
    logic signed [PW-1:0] prod1_reg [NA][3];
    logic signed [CB-1:0] base1_next [NA][3];
    logic signed [PW-1:0] prod1_next [NA][3];
    logic signed [CB:0]   diff1 [NA][3];

    // multiply stage
    always_comb begin
        for (int j = 0; j < NA; j++) begin
            for (int k = 0; k < 3; k++) begin
                diff1[j][k]      = (CB+1)'(ctrl[j][k+1]) - (CB+1)'(ctrl[j][k]);
                base1_next[j][k] = ctrl[j][k];
                prod1_next[j][k] = PW'(diff1[j][k]) * PW'(t1_s);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            base1_reg <= base1_next;
            prod1_reg <= prod1_next;
        end
    end

    // round stage
    logic signed [CB-1:0] q_reg  [NA][3];
    logic signed [CB-1:0] q_next [NA][3];
    logic signed [PW-1:0] sum1   [NA][3];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            for (int k = 0; k < 3; k++) begin
                sum1[j][k]   = prod1_reg[j][k] + HALF_LSB;
                q_next[j][k] = base1_reg[j][k] + CB'(sum1[j][k] >>> FB);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            q_reg <= q_next;
        end
    end

    // ------------------------------------------------------------------
    // Level 2: two lerps per axis
    // ------------------------------------------------------------------
    logic signed [CB-1:0] base2_reg  [NA][2];
    logic signed [PW-1:0] prod2_reg  [NA][2];
    logic signed [CB-1:0] base2_next [NA][2];
    logic signed [PW-1:0] prod2_next [NA][2];
    logic signed [CB:0]   diff2 [NA][2];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            for (int k = 0; k < 2; k++) begin
                diff2[j][k]      = (CB+1)'(q_reg[j][k+1]) - (CB+1)'(q_reg[j][k]);
                base2_next[j][k] = q_reg[j][k];
                prod2_next[j][k] = PW'(diff2[j][k]) * PW'(t3_s);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            base2_reg <= base2_next;
            prod2_reg <= prod2_next;
        end
    end

    logic signed [CB-1:0] r_reg  [NA][2];
    logic signed [CB-1:0] r_next [NA][2];
    logic signed [PW-1:0] sum2   [NA][2];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            for (int k = 0; k < 2; k++) begin
                sum2[j][k]   = prod2_reg[j][k] + HALF_LSB;
                r_next[j][k] = base2_reg[j][k] + CB'(sum2[j][k] >>> FB);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            r_reg <= r_next;
        end
    end

    // ------------------------------------------------------------------
    // Level 3: final lerp per axis
    // ------------------------------------------------------------------
    logic signed [CB-1:0] base3_reg  [NA];
    logic signed [PW-1:0] prod3_reg  [NA];
    logic signed [CB-1:0] base3_next [NA];
    logic signed [PW-1:0] prod3_next [NA];
    logic signed [CB:0]   diff3 [NA];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            diff3[j]      = (CB+1)'(r_reg[j][1]) - (CB+1)'(r_reg[j][0]);
            base3_next[j] = r_reg[j][0];
            prod3_next[j] = PW'(diff3[j]) * PW'(t5_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            base3_reg <= base3_next;
            prod3_reg <= prod3_next;
        end
    end

    // output register
    logic signed [CB-1:0] out_reg  [NA];
    logic signed [CB-1:0] out_next [NA];
    logic signed [PW-1:0] sum3     [NA];

    always_comb begin
        for (int j = 0; j < NA; j++) begin
            sum3[j]     = prod3_reg[j] + HALF_LSB;
            out_next[j] = base3_reg[j] + CB'(sum3[j] >>> FB);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            out_reg <= out_next;
        end
    end

    assign m_out_x = out_reg[0];
    assign m_out_y = out_reg[1];
    assign m_out_z = out_reg[2];

endmodule

`default_nettype wire

// File: design/cbpe_checker.sv
// ----------------------------------------------------------------------------
// cbpe_checker
// Port-level checks of the curve point evaluator: output hold under stall,
// reset behavior and back-pressure only when the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpe_checker #(
    parameter int unsigned COORD_BITS      = 16,
    parameter int unsigned PARAM_FRAC_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cbpe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [3*COORD_BITS-1:0]             cfg_wr_data,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic [PARAM_FRAC_BITS:0]            s_t_fraction,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic signed [COORD_BITS-1:0]        m_out_x,
    input  wire logic signed [COORD_BITS-1:0]        m_out_y,
    input  wire logic signed [COORD_BITS-1:0]        m_out_z
);

    // stalled result holds until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
            && $stable(m_out_z))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input is only held off when a valid output is stalled
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // input is ready during a config write while no result is valid
    a_cfg_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && !m_valid |-> s_ready)
        else $error("input stalled during config write with empty output");

    // unused in the checks above but part of the port view
    logic unused_ok;
    assign unused_ok = ^{cfg_index, cfg_wr_data, s_valid, s_t_fraction};

endmodule

bind cubic_bezier_point_eval_unit cbpe_checker #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
) u_cbpe_checker (.*);

`default_nettype wire
